// ----- rtl/ssrs_pkg.sv -----
// ssrs_pkg: shared widths, codes and state types for the servo sweep range scanner
// no dependencies; imported by servo_sweep_range_scanner_unit, its checker and its testbench
package ssrs_pkg;

  localparam int AngW      = 8;
  localparam int DistW     = 16;
  localparam int TimeW     = 32;
  localparam int ReqW      = 3;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;
  localparam int WaitW     = 9;
  localparam int RadW      = 18;
  localparam int RootW     = 9;
  localparam int RemW      = 11;
  localparam int RootSteps = 9;
  localparam int CntW      = 4;
  localparam int SumW      = 10;

  localparam logic [RadW-1:0]  SlewK    = RadW'(729);
  localparam logic [SumW-1:0]  WaitBase = SumW'(100);
  localparam logic [WaitW-1:0] WaitMax  = WaitW'(511);

  typedef enum logic [ReqW-1:0] {
    REQ_TICK       = 3'd0,
    REQ_START_SCAN = 3'd1,
    REQ_START_SRCH = 3'd2,
    REQ_STOP       = 3'd3,
    REQ_SET_ANGLE  = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_TURNING   = 2'd1,
    MODE_SCANNING  = 2'd2,
    MODE_SEARCHING = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PH_CENTER   = 2'd0,
    PH_LEFT     = 2'd1,
    PH_RIGHT    = 2'd2,
    PH_COMPLETE = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_ANGLE   = 3'd0,
    CFG_MAX_ANGLE   = 3'd1,
    CFG_FRONT_ANGLE = 3'd2,
    CFG_SEARCH_STEP = 3'd3,
    CFG_NEAR_THRESH = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_EXEC = 3'd1,
    S_PREP = 3'd2,
    S_ROOT = 3'd3,
    S_DONE = 3'd4
  } fsm_e;

endpackage

// ----- rtl/servo_sweep_range_scanner_unit.sv -----
// servo_sweep_range_scanner_unit: servo mode controller with serial turn-time root
// depends on ssrs_pkg
//
//   channel | direction | handshake              | payload
//   in      | in        | in_valid_i / in_stall_o | req_type, angle, distance, now_ms
//   out     | out       | out_valid_o / out_stall_i | servo_drive .. sensor_start
//   cfg     | in        | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// one request at a time: the update (S_EXEC) comes first; a move adds the slew setup
// (S_PREP), and a move of nonzero angle then 9 root steps of 2 bits (S_ROOT); S_DONE loads
// the result; the result register frees the input side
// reset clears all mode and scan state; no clearing pass
// a stalled result holds; the next request is taken while it waits
module servo_sweep_range_scanner_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ssrs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ssrs_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ssrs_pkg::ReqW-1:0]      req_type_i,
  input  logic [ssrs_pkg::AngW-1:0]      angle_i,
  input  logic [ssrs_pkg::DistW-1:0]     distance_i,
  input  logic [ssrs_pkg::TimeW-1:0]     now_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           servo_drive_o,
  output logic [ssrs_pkg::AngW-1:0]      servo_angle_o,
  output logic [1:0]                     mode_o,
  output logic                           object_found_o,
  output logic [ssrs_pkg::AngW-1:0]      object_angle_o,
  output logic [ssrs_pkg::DistW-1:0]     left_distance_o,
  output logic [ssrs_pkg::DistW-1:0]     center_distance_o,
  output logic [ssrs_pkg::DistW-1:0]     right_distance_o,
  output logic                           scan_done_o,
  output logic                           sensor_start_o
);
  import ssrs_pkg::*;

  // configuration
  logic [AngW-1:0]  min_q, max_q, front_q, step_q;
  logic [DistW-1:0] thr_q;

  // request
  logic [ReqW-1:0]  req_q;
  logic [AngW-1:0]  ang_q;
  logic [DistW-1:0] dist_q;
  logic [TimeW-1:0] now_q;

  // block state
  fsm_e             state_q, state_d;
  mode_e            mode_q, mode_d, after_q, after_d;
  phase_e           phase_q, phase_d;
  logic [AngW-1:0]  cur_q, cur_d, tgt_q, tgt_d, idx_q, idx_d, fang_q, fang_d;
  logic             found_q, found_d;
  logic [TimeW-1:0] start_q, start_d;
  logic [WaitW-1:0] wait_q;
  logic [DistW-1:0] left_q, left_d, center_q, center_d, right_q, right_d;
  logic             drive_q, drive_d, pulse_q, pulse_d, move_q, move_d;

  // root unit
  logic [RadW-1:0]  rad_q;
  logic [RemW-1:0]  rem_q, rem_sh, trial, rem_n;
  logic [RootW-1:0] root_q, root_n;
  logic [CntW-1:0]  cnt_q;
  logic [SumW-1:0]  wait_sum;
  logic [WaitW-1:0] wait_sat;
  logic [AngW-1:0]  slew_d;
  logic             root_last;

  // result register
  logic out_load, in_take;
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= '0;
      max_q   <= AngW'(180);
      front_q <= AngW'(90);
      step_q  <= AngW'(15);
      thr_q   <= DistW'(20);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_ANGLE:   min_q   <= cfg_data_i[AngW-1:0];
        CFG_MAX_ANGLE:   max_q   <= cfg_data_i[AngW-1:0];
        CFG_FRONT_ANGLE: front_q <= cfg_data_i[AngW-1:0];
        CFG_SEARCH_STEP: step_q  <= cfg_data_i[AngW-1:0];
        CFG_NEAR_THRESH: thr_q   <= cfg_data_i[DistW-1:0];
        default: ;
      endcase
    end
  end

  // request update
  always_comb begin
    logic            mv;
    logic [AngW-1:0] mv_ang;
    mode_e           mv_next;
    logic [TimeW-1:0] elapsed;
    logic [2*AngW:0] nxt;
    logic            near;

    mode_d   = mode_q;
    after_d  = after_q;
    phase_d  = phase_q;
    cur_d    = cur_q;
    tgt_d    = tgt_q;
    idx_d    = idx_q;
    found_d  = found_q;
    fang_d   = fang_q;
    start_d  = start_q;
    left_d   = left_q;
    center_d = center_q;
    right_d  = right_q;
    drive_d  = 1'b0;
    pulse_d  = 1'b0;
    mv       = 1'b0;
    mv_ang   = ang_q;
    mv_next  = MODE_IDLE;
    elapsed  = now_q - start_q;
    near     = (dist_q <= thr_q);
    nxt      = (2*AngW+1)'(idx_q) * (2*AngW+1)'(step_q) + (2*AngW+1)'(min_q);

    unique case (req_e'(req_q))
      REQ_TICK: begin
        if (mode_q == MODE_TURNING && elapsed >= {{(TimeW-WaitW){1'b0}}, wait_q}) begin
          cur_d  = tgt_q;
          mode_d = after_q;
        end
        if (mode_d == MODE_TURNING) begin
          drive_d = 1'b1;
        end else if (mode_d == MODE_SEARCHING) begin
          if (near) begin
            found_d = 1'b1;
            fang_d  = cur_d;
            mv      = 1'b1;
            mv_ang  = front_q;
            mv_next = MODE_IDLE;
          end else if (!found_q) begin
            mv      = 1'b1;
            mv_next = MODE_SEARCHING;
            if (nxt > {{(AngW+1){1'b0}}, max_q}) begin
              mv_ang = min_q;
              idx_d  = AngW'(1);
            end else begin
              mv_ang = nxt[AngW-1:0];
              idx_d  = idx_q + AngW'(1);
            end
          end
        end else if (mode_d == MODE_SCANNING) begin
          case (phase_q)
            PH_CENTER: begin
              if (near) begin
                center_d = dist_q;
                cur_d    = front_q;
                mv       = 1'b1;
                mv_ang   = min_q;
                mv_next  = MODE_SCANNING;
                phase_d  = PH_LEFT;
              end
            end
            PH_LEFT: begin
              left_d  = dist_q;
              cur_d   = min_q;
              mv      = 1'b1;
              mv_ang  = max_q;
              mv_next = MODE_SCANNING;
              phase_d = PH_RIGHT;
            end
            PH_RIGHT: begin
              right_d = dist_q;
              cur_d   = max_q;
              mv      = 1'b1;
              mv_ang  = front_q;
              mv_next = MODE_SCANNING;
              phase_d = PH_COMPLETE;
            end
            default: ;
          endcase
        end
      end
      REQ_START_SCAN: begin
        if (mode_q == MODE_IDLE) begin
          phase_d = PH_CENTER;
          idx_d   = '0;
          pulse_d = 1'b1;
          mode_d  = MODE_SCANNING;
        end
      end
      REQ_START_SRCH: begin
        if (mode_q == MODE_IDLE) begin
          found_d = 1'b0;
          idx_d   = '0;
          pulse_d = 1'b1;
          mode_d  = MODE_SEARCHING;
        end
      end
      REQ_STOP: mode_d = MODE_IDLE;
      REQ_SET_ANGLE: begin
        mv      = 1'b1;
        mv_ang  = ang_q;
        mv_next = MODE_IDLE;
      end
      default: ;
    endcase

    // clamp: raise to min, then lower to max
    if (mv) begin
      if (mv_ang < min_q) mv_ang = min_q;
      if (mv_ang > max_q) mv_ang = max_q;
      tgt_d   = mv_ang;
      after_d = mv_next;
      mode_d  = MODE_TURNING;
      start_d = now_q;
    end
    move_d = mv;
  end

  // one root step: two radicand bits per cycle
  assign slew_d    = (tgt_q > cur_q) ? tgt_q - cur_q : cur_q - tgt_q;
  assign rem_sh    = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial     = {root_q, 2'b01};
  assign rem_n     = (rem_sh >= trial) ? rem_sh - trial : rem_sh;
  assign root_n    = (rem_sh >= trial) ? {root_q[RootW-2:0], 1'b1} : {root_q[RootW-2:0], 1'b0};
  assign root_last = (cnt_q == CntW'(RootSteps - 1));
  assign wait_sum  = SumW'(root_n) + WaitBase;
  assign wait_sat  = (wait_sum > {1'b0, WaitMax}) ? WaitMax : wait_sum[WaitW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_take) state_d = S_EXEC;
      S_EXEC: state_d = move_d ? S_PREP : S_DONE;
      S_PREP: state_d = (slew_d == '0) ? S_DONE : S_ROOT;
      S_ROOT: if (root_last) state_d = S_DONE;
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    in_take    = in_valid_i && (state_q == S_IDLE);
    out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mode_q   <= MODE_IDLE;
      after_q  <= MODE_IDLE;
      phase_q  <= PH_CENTER;
      cur_q    <= '0;
      tgt_q    <= '0;
      idx_q    <= '0;
      found_q  <= 1'b0;
      fang_q   <= '0;
      start_q  <= '0;
      wait_q   <= '0;
      left_q   <= '0;
      center_q <= '0;
      right_q  <= '0;
      drive_q  <= 1'b0;
      pulse_q  <= 1'b0;
      move_q   <= 1'b0;
      cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EXEC) begin
        mode_q   <= mode_d;
        after_q  <= after_d;
        phase_q  <= phase_d;
        cur_q    <= cur_d;
        tgt_q    <= tgt_d;
        idx_q    <= idx_d;
        found_q  <= found_d;
        fang_q   <= fang_d;
        start_q  <= start_d;
        left_q   <= left_d;
        center_q <= center_d;
        right_q  <= right_d;
        drive_q  <= drive_d;
        pulse_q  <= pulse_d;
        move_q   <= move_d;
      end
      if (state_q == S_PREP) begin
        cnt_q <= '0;
        if (slew_d == '0) wait_q <= '0;
      end
      if (state_q == S_ROOT) begin
        cnt_q <= cnt_q + CntW'(1);
        if (root_last) wait_q <= wait_sat;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q  <= req_type_i;
      ang_q  <= angle_i;
      dist_q <= distance_i;
      now_q  <= now_ms_i;
    end
    if (state_q == S_PREP) begin
      rad_q  <= RadW'(slew_d) * SlewK;
      rem_q  <= '0;
      root_q <= '0;
    end
    if (state_q == S_ROOT) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      rem_q  <= rem_n;
      root_q <= root_n;
    end
    if (out_load) begin
      servo_drive_o     <= drive_q;
      servo_angle_o     <= tgt_q;
      mode_o            <= mode_q;
      object_found_o    <= found_q;
      object_angle_o    <= found_q ? fang_q : '0;
      left_distance_o   <= left_q;
      center_distance_o <= center_q;
      right_distance_o  <= right_q;
      scan_done_o       <= (phase_q == PH_COMPLETE);
      sensor_start_o    <= pulse_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result appeared without a finished request");

  a_drive_only_turning: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && servo_drive_o |-> mode_o == MODE_TURNING)
    else $error("servo drive outside turning");

  a_pulse_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sensor_start_o |-> mode_o == MODE_SCANNING || mode_o == MODE_SEARCHING)
    else $error("sensor start without scan or search");

  a_root_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROOT |-> cnt_q < CntW'(RootSteps))
    else $error("root step count overran");

  a_move_goes_turning: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PREP |-> move_q && mode_q == MODE_TURNING)
    else $error("slew setup without a move");

endmodule

// ----- test/servo_sweep_range_scanner_unit_chk.sv -----
// servo_sweep_range_scanner_unit_chk: watches the request, result and register ports,
// predicts the status after each request and compares it with every accepted result
// depends on ssrs_pkg; instantiated beside the DUT by servo_sweep_range_scanner_unit_tb
`timescale 1ns / 1ps

module servo_sweep_range_scanner_unit_chk (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ssrs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ssrs_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [ssrs_pkg::ReqW-1:0]      req_type_i,
  input  logic [ssrs_pkg::AngW-1:0]      angle_i,
  input  logic [ssrs_pkg::DistW-1:0]     distance_i,
  input  logic [ssrs_pkg::TimeW-1:0]     now_ms_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic                           servo_drive_i,
  input  logic [ssrs_pkg::AngW-1:0]      servo_angle_i,
  input  logic [1:0]                     mode_i,
  input  logic                           object_found_i,
  input  logic [ssrs_pkg::AngW-1:0]      object_angle_i,
  input  logic [ssrs_pkg::DistW-1:0]     left_distance_i,
  input  logic [ssrs_pkg::DistW-1:0]     center_distance_i,
  input  logic [ssrs_pkg::DistW-1:0]     right_distance_i,
  input  logic                           scan_done_i,
  input  logic                           sensor_start_i,
  output int                             fail_count_o,
  output int                             results_seen_o,
  output int                             pending_o
);
  import ssrs_pkg::*;

  typedef struct packed {
    logic             drive;
    logic [AngW-1:0]  angle;
    logic [1:0]       mode;
    logic             found;
    logic [AngW-1:0]  obj_angle;
    logic [DistW-1:0] left;
    logic [DistW-1:0] center;
    logic [DistW-1:0] right;
    logic             done;
    logic             start;
  } status_t;

  logic [AngW-1:0]  lo_ang, hi_ang, fwd_ang, step_ang;
  logic [DistW-1:0] near_lim;

  mode_e            mode_q, resume_q;
  phase_e           phase_q;
  logic [AngW-1:0]  cur_ang, tgt_ang, sweep_idx, found_at;
  logic             found_q;
  logic [TimeW-1:0] turn_t0;
  logic [WaitW-1:0] turn_wait;
  logic [DistW-1:0] dist_l, dist_c, dist_r;

  status_t status_q[$];
  status_t got_s, want_s;

  initial begin
    fail_count_o   = 0;
    results_seen_o = 0;
    pending_o      = 0;
  end

  function automatic logic [8:0] floor_root(input int unsigned v);
    logic [8:0] r;
    logic [8:0] c;
    r = '0;
    for (int b = 8; b >= 0; b--) begin
      c = r | (9'd1 << b);
      if (int'(c) * int'(c) <= v) r = c;
    end
    return r;
  endfunction

  function automatic void slew_to(input logic [AngW-1:0] a, input mode_e nxt,
                                  input logic [TimeW-1:0] t);
    logic [AngW-1:0] dest;
    int delta;
    int settle_ms;
    dest = a;
    if (dest < lo_ang) dest = lo_ang;
    if (dest > hi_ang) dest = hi_ang;
    delta = (dest > cur_ang) ? int'(dest) - int'(cur_ang) : int'(cur_ang) - int'(dest);
    if (delta == 0) begin
      settle_ms = 0;
    end else begin
      settle_ms = 100 + int'(floor_root(729 * delta));
      if (settle_ms > 511) settle_ms = 511;
    end
    turn_wait = WaitW'(settle_ms);
    tgt_ang   = dest;
    resume_q  = nxt;
    mode_q    = MODE_TURNING;
    turn_t0   = t;
  endfunction

  function automatic status_t advance_scanner(input logic [ReqW-1:0] req,
                                              input logic [AngW-1:0] ang,
                                              input logic [DistW-1:0] rng,
                                              input logic [TimeW-1:0] t);
    status_t s;
    logic drive, pulse;
    logic [TimeW-1:0] elapsed;
    int step_to;
    drive = 1'b0;
    pulse = 1'b0;
    case (req)
      REQ_TICK: begin
        elapsed = t - turn_t0;
        if (mode_q == MODE_TURNING && elapsed >= TimeW'(turn_wait)) begin
          cur_ang = tgt_ang;
          mode_q  = resume_q;
        end
        if (mode_q == MODE_TURNING) begin
          drive = 1'b1;
        end else begin
          if (mode_q == MODE_SEARCHING) begin
            if (rng <= near_lim) begin
              found_q  = 1'b1;
              found_at = cur_ang;
              slew_to(fwd_ang, MODE_IDLE, t);
            end
            if (!found_q) begin
              step_to = int'(lo_ang) + int'(sweep_idx) * int'(step_ang);
              if (step_to > int'(hi_ang)) begin
                step_to   = int'(lo_ang);
                sweep_idx = '0;
              end
              slew_to(AngW'(step_to), MODE_SEARCHING, t);
              sweep_idx = sweep_idx + 8'd1;
            end
          end
          if (mode_q == MODE_SCANNING) begin
            case (phase_q)
              PH_CENTER: begin
                if (rng <= near_lim) begin
                  dist_c  = rng;
                  cur_ang = fwd_ang;
                  slew_to(lo_ang, MODE_SCANNING, t);
                  phase_q = PH_LEFT;
                end
              end
              PH_LEFT: begin
                dist_l  = rng;
                cur_ang = lo_ang;
                slew_to(hi_ang, MODE_SCANNING, t);
                phase_q = PH_RIGHT;
              end
              PH_RIGHT: begin
                dist_r  = rng;
                phase_q = PH_COMPLETE;
                cur_ang = hi_ang;
                slew_to(fwd_ang, MODE_SCANNING, t);
              end
              default: ;
            endcase
          end
        end
      end
      REQ_START_SCAN: begin
        if (mode_q == MODE_IDLE) begin
          phase_q   = PH_CENTER;
          sweep_idx = '0;
          pulse     = 1'b1;
          mode_q    = MODE_SCANNING;
        end
      end
      REQ_START_SRCH: begin
        if (mode_q == MODE_IDLE) begin
          found_q   = 1'b0;
          sweep_idx = '0;
          pulse     = 1'b1;
          mode_q    = MODE_SEARCHING;
        end
      end
      REQ_STOP:      mode_q = MODE_IDLE;
      REQ_SET_ANGLE: slew_to(ang, MODE_IDLE, t);
      default: ;
    endcase
    s.drive     = drive;
    s.angle     = tgt_ang;
    s.mode      = mode_q;
    s.found     = found_q;
    s.obj_angle = found_q ? found_at : '0;
    s.left      = dist_l;
    s.center    = dist_c;
    s.right     = dist_r;
    s.done      = (phase_q == PH_COMPLETE);
    s.start     = pulse;
    return s;
  endfunction

  task automatic check_field(input string nm, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_ang    = 8'd0;
      hi_ang    = 8'd180;
      fwd_ang   = 8'd90;
      step_ang  = 8'd15;
      near_lim  = 16'd20;
      mode_q    = MODE_IDLE;
      resume_q  = MODE_IDLE;
      phase_q   = PH_CENTER;
      cur_ang   = '0;
      tgt_ang   = '0;
      sweep_idx = '0;
      found_q   = 1'b0;
      found_at  = '0;
      turn_t0   = '0;
      turn_wait = '0;
      dist_l    = '0;
      dist_c    = '0;
      dist_r    = '0;
      status_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_ANGLE:   lo_ang   = cfg_data_i[AngW-1:0];
          CFG_MAX_ANGLE:   hi_ang   = cfg_data_i[AngW-1:0];
          CFG_FRONT_ANGLE: fwd_ang  = cfg_data_i[AngW-1:0];
          CFG_SEARCH_STEP: step_ang = cfg_data_i[AngW-1:0];
          CFG_NEAR_THRESH: near_lim = cfg_data_i[DistW-1:0];
          default: ;
        endcase
      end
      // results first, so a request taken at this edge never matches a result of this edge
      if (out_valid_i && !out_stall_i) begin
        results_seen_o++;
        got_s = '{servo_drive_i, servo_angle_i, mode_i, object_found_i, object_angle_i,
                  left_distance_i, center_distance_i, right_distance_i, scan_done_i,
                  sensor_start_i};
        if (status_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with no request pending, got angle %0d mode %0d",
                   $time, got_s.angle, got_s.mode);
        end else begin
          want_s = status_q.pop_front();
          check_field("servo_drive", want_s.drive, got_s.drive);
          check_field("servo_angle", want_s.angle, got_s.angle);
          check_field("mode", want_s.mode, got_s.mode);
          check_field("object_found", want_s.found, got_s.found);
          check_field("object_angle", want_s.obj_angle, got_s.obj_angle);
          check_field("left_distance", want_s.left, got_s.left);
          check_field("center_distance", want_s.center, got_s.center);
          check_field("right_distance", want_s.right, got_s.right);
          check_field("scan_done", want_s.done, got_s.done);
          check_field("sensor_start", want_s.start, got_s.start);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        status_q.push_back(advance_scanner(req_type_i, angle_i, distance_i, now_ms_i));
      end
    end
    pending_o = status_q.size();
  end

endmodule

// ----- test/servo_sweep_range_scanner_unit_tb.sv -----
// servo_sweep_range_scanner_unit_tb: directed and random request streams under several
// register settings, random idling on both channels and one long output hold-off
// depends on ssrs_pkg, servo_sweep_range_scanner_unit and servo_sweep_range_scanner_unit_chk
`timescale 1ns / 1ps

module servo_sweep_range_scanner_unit_tb;
  import ssrs_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int Phases      = 8;
  localparam int PhaseItems  = 85;
  localparam int HoldPhase   = 3;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 16;
  localparam logic [CfgIdxW-1:0] CfgSpareIdx = 3'd7;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [ReqW-1:0]     req_type_i;
  logic [AngW-1:0]     angle_i;
  logic [DistW-1:0]    distance_i;
  logic [TimeW-1:0]    now_ms_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                servo_drive_o;
  logic [AngW-1:0]     servo_angle_o;
  logic [1:0]          mode_o;
  logic                object_found_o;
  logic [AngW-1:0]     object_angle_o;
  logic [DistW-1:0]    left_distance_o;
  logic [DistW-1:0]    center_distance_o;
  logic [DistW-1:0]    right_distance_o;
  logic                scan_done_o;
  logic                sensor_start_o;

  int fail_count, results_seen, pending;
  int sent = 0;
  int cycles = 0;
  int near_thr = 20;
  logic [TimeW-1:0] tnow;
  logic gaps_on = 1'b1;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  always #1 clk_i = ~clk_i;

  servo_sweep_range_scanner_unit DUT (.*);

  servo_sweep_range_scanner_unit_chk u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .req_type_i, .angle_i, .distance_i, .now_ms_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .servo_drive_i(servo_drive_o), .servo_angle_i(servo_angle_o), .mode_i(mode_o),
    .object_found_i(object_found_o), .object_angle_i(object_angle_o),
    .left_distance_i(left_distance_o), .center_distance_i(center_distance_o),
    .right_distance_i(right_distance_o), .scan_done_i(scan_done_o),
    .sensor_start_i(sensor_start_o),
    .fail_count_o(fail_count), .results_seen_o(results_seen), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("** servo_sweep_range_scanner_unit: FAILED **");
      $finish;
    end
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [DistW-1:0] near_or_far(input int pct);
    if ($urandom_range(0, 99) < pct) return DistW'($urandom_range(0, near_thr));
    return DistW'($urandom);
  endfunction

  task automatic send_req(input logic [ReqW-1:0] req, input logic [AngW-1:0] ang,
                          input logic [DistW-1:0] rng, input logic [TimeW-1:0] t);
    int gap;
    req_type_i <= req;
    angle_i    <= ang;
    distance_i <= rng;
    now_ms_i   <= t;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
    gap = gaps_on ? pick_idle() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic tick(input logic [DistW-1:0] rng);
    if ($urandom_range(0, 39) == 0) tnow = $urandom;
    else tnow += $urandom_range(0, 250);
    send_req(REQ_TICK, AngW'($urandom), rng, tnow);
  endtask

  task automatic apply_cfg(input int mn, input int mx, input int fr, input int st,
                           input int th, input logic spare);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MIN_ANGLE;
    cfg_data_i <= CfgDataW'(mn);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAX_ANGLE;
    cfg_data_i <= CfgDataW'(mx);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_FRONT_ANGLE;
    cfg_data_i <= CfgDataW'(fr);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SEARCH_STEP;
    cfg_data_i <= CfgDataW'(st);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_NEAR_THRESH;
    cfg_data_i <= CfgDataW'(th);
    @(posedge clk_i);
    if (spare) begin
      cfg_idx_i  <= CfgSpareIdx;
      cfg_data_i <= CfgDataW'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    near_thr = th;
  endtask

  // receiver: random stalls, free stretches, and one long hold-off on request
  initial begin
    int stall_cnt, free_cnt;
    stall_cnt = 0;
    free_cnt  = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done <= 1'b1;
      end else begin
        if (stall_cnt <= 0 && free_cnt <= 0) begin
          stall_cnt = pick_idle();
          free_cnt  = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 4);
        end
        if (stall_cnt > 0) begin
          stall_cnt--;
          out_stall_i <= 1'b1;
        end else begin
          free_cnt--;
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  initial begin
    int r, start_cnt;
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CFG_MIN_ANGLE;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    req_type_i <= REQ_TICK;
    angle_i    <= '0;
    distance_i <= '0;
    now_ms_i   <= '0;
    tnow = 32'hFFFF_FF00;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: clamp, no-move turn, stop while turning, full scan, search hit at threshold
    send_req(REQ_TICK, 8'hFF, 16'hFFFF, tnow);
    send_req(REQ_SET_ANGLE, 8'hFF, 16'h0000, tnow);
    tnow += 10;
    send_req(REQ_TICK, 8'h00, 16'h0000, tnow);
    tnow += 600;
    send_req(REQ_TICK, 8'h00, 16'h0000, tnow);
    send_req(REQ_SET_ANGLE, 8'd180, 16'h0000, tnow);
    send_req(REQ_TICK, 8'h00, 16'h0000, tnow);
    send_req(REQ_SET_ANGLE, 8'h00, 16'h0000, tnow);
    send_req(REQ_STOP, 8'h00, 16'h0000, tnow);
    send_req(REQ_START_SCAN, 8'h00, 16'h0000, tnow);
    send_req(REQ_START_SRCH, 8'h00, 16'h0000, tnow);
    send_req(REQ_TICK, 8'h00, DistW'(near_thr + 1), tnow);
    send_req(REQ_TICK, 8'h00, 16'h0000, tnow);
    repeat (3) begin
      tnow += 600;
      send_req(REQ_TICK, 8'h00, DistW'($urandom), tnow);
    end
    send_req(REQ_STOP, 8'h00, 16'h0000, tnow);
    send_req(REQ_START_SRCH, 8'h00, 16'h0000, tnow);
    send_req(REQ_TICK, 8'h00, 16'hFFFF, tnow);
    tnow += 600;
    send_req(REQ_TICK, 8'h00, 16'd1000, tnow);
    tnow += 600;
    send_req(REQ_TICK, 8'h00, DistW'(near_thr), tnow);
    tnow += 600;
    send_req(REQ_TICK, 8'h00, 16'hFFFF, tnow);
    for (int u = int'(REQ_SET_ANGLE) + 1; u < (1 << ReqW); u++) begin
      send_req(ReqW'(u), 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    end
    send_req(REQ_TICK, 8'h00, 16'h0000, 32'h0000_0000);
    in_valid_i <= 1'b0;
    while (results_seen < sent) @(posedge clk_i);

    for (int p = 0; p < Phases; p++) begin
      case (p)
        0: apply_cfg(0, 180, 90, 15, 20, 1'b0);
        1: apply_cfg(0, 180, 0, 1, 0, 1'b0);
        2: apply_cfg(180, 180, 180, 180, 65535, 1'b0);
        3: apply_cfg(30, 150, 90, 45, 300, 1'b0);
        4: apply_cfg(120, 40, 90, 0, 500, 1'b1);
        5: apply_cfg(0, 255, 255, 255, 1000, 1'b0);
        6: apply_cfg($urandom_range(0, 90), $urandom_range(90, 180), $urandom_range(0, 180),
                     $urandom_range(1, 180), $urandom_range(0, 65535), 1'b0);
        default: apply_cfg(0, 180, 90, 7, 2000, 1'b0);
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      if (p == HoldPhase) hold_req <= 1'b1;
      start_cnt = sent;
      while (sent - start_cnt < PhaseItems) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          if ($urandom_range(0, 9) < 8) send_req(REQ_STOP, AngW'($urandom), DistW'($urandom), tnow);
          send_req(REQ_START_SCAN, AngW'($urandom), DistW'($urandom), tnow);
          repeat ($urandom_range(6, 16)) begin
            if ($urandom_range(0, 29) == 0) send_req(REQ_STOP, 8'h00, 16'h0000, tnow);
            else tick(near_or_far(45));
          end
        end else if (r < 65) begin
          if ($urandom_range(0, 9) < 8) send_req(REQ_STOP, AngW'($urandom), DistW'($urandom), tnow);
          send_req(REQ_START_SRCH, AngW'($urandom), DistW'($urandom), tnow);
          repeat ($urandom_range(4, 20)) tick(near_or_far(12));
        end else if (r < 80) begin
          send_req(REQ_SET_ANGLE, AngW'($urandom), DistW'($urandom), tnow);
          repeat ($urandom_range(1, 4)) tick(near_or_far(30));
        end else if (r < 88) begin
          send_req(REQ_STOP, AngW'($urandom), DistW'($urandom), tnow);
        end else begin
          send_req(ReqW'($urandom), AngW'($urandom), DistW'($urandom), $urandom);
        end
      end
      in_valid_i <= 1'b0;
      while (results_seen < sent) @(posedge clk_i);
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("run covered %0d requests across %0d register settings, %0d results compared",
             sent, Phases + 1, results_seen);
    $display("output held off for %0d cycles once while requests kept coming", HoldCycles);
    if (fail_count == 0 && pending == 0) begin
      $display("** servo_sweep_range_scanner_unit: PASSED **");
    end else begin
      $display("** servo_sweep_range_scanner_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ssrs_pkg.sv
rtl/servo_sweep_range_scanner_unit.sv
test/servo_sweep_range_scanner_unit_chk.sv
test/servo_sweep_range_scanner_unit_tb.sv
